// ===== hdl/cstb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cstb_pkg
// Characters, queue sizing and the result entry type of the comment and
// literal blanker.
// ----------------------------------------------------------------------------
package cstb_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // result queue: four entries, room for two beats is needed to take a byte
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       text_done;
      logic       run_last;
      logic [7:0] clean_byte;
   } cstb_entry_type;

endpackage : cstb_pkg
`default_nettype wire

// ===== hdl/c_comment_string_blanker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_comment_string_blanker
// Streams C source text and blanks comments and string/char literals.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per beat; req_tlast marks the final byte
//   of a text. rsp_* returns the cleaned bytes, one per beat. rsp_tlast is
//   high on the last beat caused by an input byte, rsp_tuser on the final
//   beat of the whole text. An input byte causes zero, one or two beats: a
//   slash in code is held until the next byte, which may release both.
//   A beat is queued as its byte is taken and can be offered in the next cycle.
//   Throughput: one byte per cycle while bytes yield at most one beat each
//   and rsp_tready stays high; the output side moves one beat per cycle,
//   so two-beat bytes fill the queue. A four-entry result queue sits
//   between the mode machine and rsp_*; req_tready is high while the queue
//   holds two entries or fewer, so input keeps flowing while a finished
//   beat waits to be taken.
//   Reset empties the queue and returns the scanner to normal code mode.
//   When the receiver stalls, the queue fills and req_tready drops; no beat
//   is lost. After each final byte the scanner returns to code mode.
// ----------------------------------------------------------------------------
module c_comment_string_blanker
   import cstb_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] text_byte
   input  wire        req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] clean_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // [0] text_done
);

   localparam logic [3:0] MODE_CODE    = 4'd0;
   localparam logic [3:0] MODE_SLASH   = 4'd1;
   localparam logic [3:0] MODE_LINE    = 4'd2;
   localparam logic [3:0] MODE_BLOCK   = 4'd3;
   localparam logic [3:0] MODE_BSTAR   = 4'd4;
   localparam logic [3:0] MODE_STR     = 4'd5;
   localparam logic [3:0] MODE_STR_ESC = 4'd6;
   localparam logic [3:0] MODE_CHR     = 4'd7;
   localparam logic [3:0] MODE_CHR_ESC = 4'd8;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

   logic [3:0]       mode_ff, mode_in;
   cstb_entry_type   queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;

   logic       req_fire, rsp_fire, last;
   logic [7:0] c;
   logic [1:0] push_cnt;
   logic [7:0] byte0, byte1;
   cstb_entry_type entry0, entry1;

   // normal code mode handling of the current byte
   logic       cb_push;
   logic [7:0] cb_byte;
   logic [3:0] cb_mode;

   assign c        = req_tdata;
   assign last     = req_tlast;
   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   always_comb begin
      cb_push = 1'b1;
      cb_byte = c;
      cb_mode = MODE_CODE;
      if (c == CH_SLASH && !last) begin
         cb_push = 1'b0;
         cb_mode = MODE_SLASH;
      end else if (c == CH_DQUOTE) begin
         cb_byte = CH_SPACE;
         cb_mode = MODE_STR;
      end else if (c == CH_SQUOTE) begin
         cb_byte = CH_SPACE;
         cb_mode = MODE_CHR;
      end
   end

   always_comb begin
      push_cnt = 2'd1;
      byte0    = (c == CH_NL) ? CH_NL : CH_SPACE;
      byte1    = CH_SPACE;
      mode_in  = mode_ff;
      unique case (mode_ff) inside
         MODE_SLASH: begin
            if (c == CH_SLASH || c == CH_STAR) begin
               push_cnt = 2'd2;
               byte0    = CH_SPACE;
               mode_in  = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            end else begin
               // release the held slash, then treat the byte as code
               push_cnt = 2'd1 + {1'b0, cb_push};
               byte0    = CH_SLASH;
               byte1    = cb_byte;
               mode_in  = cb_mode;
            end
         end
         MODE_LINE: begin
            if (c == CH_NL) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_BLOCK, MODE_BSTAR: begin
            if (mode_ff == MODE_BSTAR && c == CH_SLASH) begin
               mode_in = MODE_CODE;
            end else begin
               mode_in = (c == CH_STAR) ? MODE_BSTAR : MODE_BLOCK;
            end
         end
         MODE_STR: begin
            if (c == CH_BSLASH) begin
               mode_in = MODE_STR_ESC;
            end else if (c == CH_DQUOTE) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_CHR: begin
            if (c == CH_BSLASH) begin
               mode_in = MODE_CHR_ESC;
            end else if (c == CH_SQUOTE) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_STR_ESC: begin
            byte0   = CH_SPACE;
            mode_in = MODE_STR;
         end
         MODE_CHR_ESC: begin
            byte0   = CH_SPACE;
            mode_in = MODE_CHR;
         end
         default: begin
            push_cnt = {1'b0, cb_push};
            byte0    = cb_byte;
            mode_in  = cb_mode;
         end
      endcase
      if (last) begin
         mode_in = MODE_CODE;
      end
   end

   always_comb begin
      entry0.clean_byte = byte0;
      entry0.run_last   = (push_cnt == 2'd1);
      entry0.text_done  = last && (push_cnt == 2'd1);
      entry1.clean_byte = byte1;
      entry1.run_last   = 1'b1;
      entry1.text_done  = last;
   end

   assign wr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
         count_in  = count_in + CNT_W'(push_cnt);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_CODE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (req_fire) begin
            mode_ff <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= entry0;
      end
      if (req_fire && push_cnt == 2'd2) begin
         queue_ff[wr_next] <= entry1;
      end
   end

   assign req_tready = (count_ff <= CNT_LIMIT);
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff].clean_byte;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].run_last;
   assign rsp_tuser  = queue_ff[rd_ptr_ff].text_done;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_room_on_take: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("byte taken without room for its beats");

   a_last_resets_mode: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> mode_ff == MODE_CODE)
      else $error("scanner not back in code mode after final byte");

   a_silent_is_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_cnt == 2'd0) |=> mode_ff == MODE_SLASH)
      else $error("byte produced no beat without holding a slash");
`endif

endmodule : c_comment_string_blanker
`default_nettype wire

// ===== tb/tb_c_comment_string_blanker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_comment_string_blanker
// Self-checking bench for the C comment and literal blanker.
// Feeds byte streams of C-like text, predicts every cleaned beat with a
// local copy of the scan mode machine, and compares each output beat field
// by field. Both sides idle at random, and a long output stall fills the
// result queue so the input side has to back off.
// ----------------------------------------------------------------------------
module tb_c_comment_string_blanker;
   import cstb_pkg::*;

   localparam int CLK_HALF_NS  = 4;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES  = 200;
   localparam int TAIL_CYCLES  = 8;
   localparam int LIMIT_NS     = 2_000_000;

   typedef enum logic [3:0] {
      SCAN_CODE,
      SCAN_SLASH,
      SCAN_LINE,
      SCAN_BLOCK,
      SCAN_BSTAR,
      SCAN_STR,
      SCAN_STR_ESC,
      SCAN_CHR,
      SCAN_CHR_ESC
   } scan_mode_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] text_byte
   logic       req_tlast;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] clean_byte
   logic       rsp_tlast;    // run_last
   logic       rsp_tuser;    // [0] text_done

   scan_mode_type  scan_state;
   cstb_entry_type clean_due[$];
   cstb_entry_type want;

   bit idle_on;
   bit hold_request;
   int errors;
   int bytes_sent;
   int texts_sent;
   int beats_seen;
   int pair_count;

   c_comment_string_blanker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

   // Work out the cleaned beats one source byte releases and advance the mode.
   function automatic void predict_clean(input logic [7:0] c, input logic last);
      logic [7:0] outs[$];
      logic [7:0] blank;
      bit         in_code;
      cstb_entry_type e;
      blank   = (c == CH_NL) ? CH_NL : CH_SPACE;
      in_code = 1'b0;
      case (scan_state) inside
         SCAN_SLASH: begin
            if (c == CH_SLASH || c == CH_STAR) begin
               outs.push_back(CH_SPACE);
               outs.push_back(CH_SPACE);
               scan_state = (c == CH_SLASH) ? SCAN_LINE : SCAN_BLOCK;
            end else begin
               // release the held slash, then treat this byte as code
               outs.push_back(CH_SLASH);
               in_code = 1'b1;
            end
         end
         SCAN_LINE: begin
            outs.push_back(blank);
            if (c == CH_NL) scan_state = SCAN_CODE;
         end
         SCAN_BLOCK, SCAN_BSTAR: begin
            outs.push_back(blank);
            if (scan_state == SCAN_BSTAR && c == CH_SLASH) scan_state = SCAN_CODE;
            else scan_state = (c == CH_STAR) ? SCAN_BSTAR : SCAN_BLOCK;
         end
         SCAN_STR: begin
            outs.push_back(blank);
            if (c == CH_BSLASH) scan_state = SCAN_STR_ESC;
            else if (c == CH_DQUOTE) scan_state = SCAN_CODE;
         end
         SCAN_CHR: begin
            outs.push_back(blank);
            if (c == CH_BSLASH) scan_state = SCAN_CHR_ESC;
            else if (c == CH_SQUOTE) scan_state = SCAN_CODE;
         end
         SCAN_STR_ESC: begin
            outs.push_back(CH_SPACE);
            scan_state = SCAN_STR;
         end
         SCAN_CHR_ESC: begin
            outs.push_back(CH_SPACE);
            scan_state = SCAN_CHR;
         end
         default: in_code = 1'b1;
      endcase
      if (in_code) begin
         if (c == CH_SLASH && !last) begin
            scan_state = SCAN_SLASH;
         end else if (c == CH_DQUOTE) begin
            outs.push_back(CH_SPACE);
            scan_state = SCAN_STR;
         end else if (c == CH_SQUOTE) begin
            outs.push_back(CH_SPACE);
            scan_state = SCAN_CHR;
         end else begin
            outs.push_back(c);
            scan_state = SCAN_CODE;
         end
      end
      if (outs.size() == 2) pair_count++;
      foreach (outs[i]) begin
         e.clean_byte = outs[i];
         e.run_last   = (i == outs.size() - 1);
         e.text_done  = last && (i == outs.size() - 1);
         clean_due.push_back(e);
      end
      if (last) scan_state = SCAN_CODE;
   endfunction

   // Interesting C characters most of the time, any byte now and then.
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      if ($urandom_range(99) < 15) begin
         b = 8'($urandom_range(255));
      end else begin
         case ($urandom_range(11))
            0:       b = CH_SLASH;
            1:       b = CH_STAR;
            2:       b = CH_DQUOTE;
            3:       b = CH_SQUOTE;
            4:       b = CH_BSLASH;
            5:       b = CH_NL;
            6:       b = CH_SPACE;
            default: b = 8'h61 + 8'($urandom_range(25));
         endcase
      end
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(99) < 33) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_clean(b, last);
      bytes_sent++;
      if (last) texts_sent++;
   endtask

   task automatic send_string(input string src, input bit mark_end);
      for (int i = 0; i < src.len(); i++)
         send_byte(src[i], mark_end && (i == src.len() - 1));
   endtask

   task automatic send_text(input int len);
      for (int i = 0; i < len; i++)
         send_byte(pick_byte(), i == len - 1);
   endtask

   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_string("a", 1'b0);
   endtask

   task automatic test_comments();
      // slash in code, line comment, block comment whose opener star is not a closer
      send_string("a/b", 1'b0);
      send_string("//x\n", 1'b0);
      send_string("/*/*/", 1'b0);
   endtask

   task automatic test_literals();
      // escaped quote inside a string, escaped newline inside a char literal
      send_string("\"\\\"\"", 1'b0);
      send_string("'\\\n'", 1'b0);
   endtask

   task automatic test_end_of_text();
      // slash as final byte, then an unclosed string cut off by the end mark
      send_string("/", 1'b1);
      send_string("\"q", 1'b1);
   endtask

   task automatic test_random_text();
      int stop_at;
      idle_on = 1'b1;
      stop_at = bytes_sent + 280;
      while (bytes_sent < stop_at) send_text($urandom_range(4, 24));
   endtask

   task automatic test_steady_flow();
      int stop_at;
      idle_on = 1'b0;
      stop_at = bytes_sent + 100;
      while (bytes_sent < stop_at) send_text($urandom_range(4, 24));
   endtask

   task automatic test_back_pressure();
      idle_on      = 1'b1;
      hold_request = 1'b1;
      send_text(40);
   endtask

   // Receiver: random idling, plus one long hold-off on request.
   initial begin
      int held;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (clean_due.size() == 0) begin
            $error("unexpected beat: clean_byte=%h run_last=%b text_done=%b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            want = clean_due.pop_front();
            if (rsp_tdata !== want.clean_byte) begin
               $error("clean_byte: expected %h, got %h", want.clean_byte, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== want.text_done) begin
               $error("text_done: expected %b, got %b", want.text_done, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tlast    = 1'b0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      errors       = 0;
      bytes_sent   = 0;
      texts_sent   = 0;
      beats_seen   = 0;
      pair_count   = 0;
      scan_state   = SCAN_CODE;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_byte_extremes();
      test_comments();
      test_literals();
      test_end_of_text();
      test_random_text();
      test_back_pressure();
      test_steady_flow();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (clean_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d source bytes in %0d texts, including a long output stall.",
               bytes_sent, texts_sent);
      $display("Checked %0d result beats; %0d bytes released a held slash pair.",
               beats_seen, pair_count);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule : tb_c_comment_string_blanker

// ===== c_comment_string_blanker.f =====
hdl/cstb_pkg.sv
hdl/c_comment_string_blanker.sv
tb/tb_c_comment_string_blanker.sv
